FILE: hw/rtl/bhmc_pkg.sv
`default_nettype none

package bhmc_pkg;

    // Field widths
    localparam int POS_W   = 8;
    localparam int PCT_W   = 8;
    localparam int STATE_W = 4;
    localparam int OPT_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Divider sizing: dividend holds 100 * 255
    localparam int DIV_DVD_W = 15;
    localparam int DIV_DSR_W = 8;

    // Duty threshold: (quotient + 1) * 20, quotient up to 255
    localparam int DUTY_W = 14;

    localparam int PCT_SCALE = 100;
    localparam int PCT_SAT   = 255;
    localparam int STEP_T1   = 20;
    localparam int STEP_T2   = 40;
    localparam int STEP_T3   = 60;
    localparam int STEP_T4   = 80;
    localparam int DUTY_STEP = 20;
    localparam int HYST      = 5;

    // Register reset values
    localparam logic [7:0]       ON_THR_RST   = 8'd128;
    localparam logic [7:0]       LOW_THR_RST  = 8'd20;
    localparam logic [7:0]       HIGH_THR_RST = 8'd235;
    localparam logic [OPT_W-1:0] OPT_RST      = 3'd0;
    localparam logic [7:0]       PW_RST       = 8'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_W  = 3'd4;

    // Option bits
    localparam int OPT_ESTOP = 0;
    localparam int OPT_VAR   = 1;
    localparam int OPT_STEP  = 2;

    typedef enum logic [STATE_W-1:0] {
        ST_LOW_BEGIN  = 4'd0,
        ST_LOW_WAIT   = 4'd1,
        ST_T1_BEGIN   = 4'd2,
        ST_T1_WAIT    = 4'd3,
        ST_T2_BEGIN   = 4'd4,
        ST_T2_WAIT    = 4'd5,
        ST_T3_BEGIN   = 4'd6,
        ST_T3_WAIT    = 4'd7,
        ST_T4_BEGIN   = 4'd8,
        ST_T4_WAIT    = 4'd9,
        ST_FULL_BEGIN = 4'd10,
        ST_FULL_WAIT  = 4'd11
    } brake_state_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PCT,
        SEQ_DUTY,
        SEQ_COMMIT
    } seq_state_t;

    typedef struct packed {
        logic [7:0]       on_thr;
        logic [7:0]       low_thr;
        logic [7:0]       high_thr;
        logic [OPT_W-1:0] options;
        logic [7:0]       pulse_width;
    } bhmc_cfg_t;

    typedef struct packed {
        logic         brake_on;
        logic         brake_off;
        logic         emergency;
        brake_state_t state;
    } mode_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bhmc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bhmc_div (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [bhmc_pkg::DIV_DVD_W-1:0]   dividend,
    input  wire  [bhmc_pkg::DIV_DSR_W-1:0]   divisor,
    output logic                             busy,
    output logic                             done,
    output logic [bhmc_pkg::DIV_DVD_W-1:0]   quotient
);

    localparam int DW    = bhmc_pkg::DIV_DVD_W;
    localparam int SW    = bhmc_pkg::DIV_DSR_W;
    localparam int CNT_W = $clog2(DW);

    logic [DW-1:0]    dvd_reg, dvd_next;
    logic [SW:0]      rem_reg, rem_next;
    logic [SW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SW:0]      rem_shift;
    logic             qbit;

    always_comb
    begin
        rem_shift = {rem_reg[SW-1:0], dvd_reg[DW-1]};
        qbit      = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = qbit ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
        dvd_next  = {dvd_reg[DW-2:0], qbit};
        cnt_next  = cnt_reg - CNT_W'(1);
        busy_next = busy_reg && (cnt_reg != '0);
        done_next = busy_reg && (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DW - 1);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bhmc_mode.sv
`default_nettype none

// Brake mode state and flags; advance once per commit.
module bhmc_mode (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             commit,
    input  wire  [bhmc_pkg::POS_W-1:0]      pos,
    input  wire  [bhmc_pkg::PCT_W-1:0]      pct,
    input  wire  [7:0]                      duty_q,
    input  bhmc_pkg::bhmc_cfg_t             cfg,
    output bhmc_pkg::mode_status_t          status
);

    localparam int DW = bhmc_pkg::DUTY_W;

    localparam logic [7:0] PCT_T1 = 8'(bhmc_pkg::STEP_T1);
    localparam logic [7:0] PCT_T2 = 8'(bhmc_pkg::STEP_T2);
    localparam logic [7:0] PCT_T3 = 8'(bhmc_pkg::STEP_T3);
    localparam logic [7:0] PCT_T4 = 8'(bhmc_pkg::STEP_T4);

    bhmc_pkg::brake_state_t state_reg, state_next;
    logic apply_reg, apply_next;
    logic release_reg, release_next;
    logic estop_reg, estop_next;

    logic          below;
    logic          above;
    logic          var_en;
    logic          stp_en;
    logic [DW-1:0] duty;
    logic          at_duty;
    logic [7:0]    lim;

    always_comb
    begin
        below   = pos < cfg.low_thr;
        above   = pos > cfg.high_thr;
        var_en  = cfg.options[bhmc_pkg::OPT_VAR];
        stp_en  = cfg.options[bhmc_pkg::OPT_STEP];
        duty    = (DW'(duty_q) + DW'(1)) * DW'(bhmc_pkg::DUTY_STEP);
        at_duty = DW'(pct) >= duty;
        lim     = (cfg.on_thr > 8'(bhmc_pkg::HYST)) ? (cfg.on_thr - 8'(bhmc_pkg::HYST)) : 8'd0;
        if (cfg.low_thr > lim)
        begin
            lim = cfg.low_thr;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        apply_next   = apply_reg;
        release_next = release_reg;
        estop_next   = estop_reg;

        if (cfg.options[bhmc_pkg::OPT_ESTOP])
        begin
            if (below)
            begin
                estop_next = 1'b0;
            end
            if (above)
            begin
                estop_next = 1'b1;
            end
        end
        else
        begin
            estop_next = 1'b0;
        end

        if (var_en && stp_en)
        begin
            case (state_reg)
                bhmc_pkg::ST_LOW_BEGIN:
                begin
                    release_next = 1'b1;
                    state_next   = bhmc_pkg::ST_LOW_WAIT;
                end
                bhmc_pkg::ST_LOW_WAIT:
                begin
                    release_next = 1'b0;
                    if (pct >= PCT_T1)
                    begin
                        state_next = bhmc_pkg::ST_T1_BEGIN;
                    end
                end
                bhmc_pkg::ST_T1_BEGIN, bhmc_pkg::ST_T2_BEGIN, bhmc_pkg::ST_T3_BEGIN,
                bhmc_pkg::ST_T4_BEGIN, bhmc_pkg::ST_FULL_BEGIN:
                begin
                    apply_next = 1'b1;
                    state_next = bhmc_pkg::brake_state_t'(state_reg + 4'd1);
                end
                bhmc_pkg::ST_T1_WAIT:
                begin
                    apply_next = 1'b0;
                    if (below)
                    begin
                        state_next = bhmc_pkg::ST_LOW_BEGIN;
                    end
                    else if (pct >= PCT_T2)
                    begin
                        state_next = bhmc_pkg::ST_T2_BEGIN;
                    end
                end
                bhmc_pkg::ST_T2_WAIT:
                begin
                    apply_next = 1'b0;
                    if (below)
                    begin
                        state_next = bhmc_pkg::ST_LOW_BEGIN;
                    end
                    else if (pct >= PCT_T3)
                    begin
                        state_next = bhmc_pkg::ST_T3_BEGIN;
                    end
                end
                bhmc_pkg::ST_T3_WAIT:
                begin
                    apply_next = 1'b0;
                    if (below)
                    begin
                        state_next = bhmc_pkg::ST_LOW_BEGIN;
                    end
                    else if (pct >= PCT_T4)
                    begin
                        state_next = bhmc_pkg::ST_T4_BEGIN;
                    end
                end
                bhmc_pkg::ST_T4_WAIT:
                begin
                    apply_next = 1'b0;
                    if (below)
                    begin
                        state_next = bhmc_pkg::ST_LOW_BEGIN;
                    end
                    else if (above)
                    begin
                        state_next = bhmc_pkg::ST_FULL_BEGIN;
                    end
                end
                bhmc_pkg::ST_FULL_WAIT:
                begin
                    apply_next = 1'b0;
                    if (below)
                    begin
                        state_next = bhmc_pkg::ST_LOW_BEGIN;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        else if (var_en)
        begin
            case (state_reg)
                bhmc_pkg::ST_LOW_BEGIN:
                begin
                    apply_next = 1'b0;
                    state_next = bhmc_pkg::ST_LOW_WAIT;
                end
                bhmc_pkg::ST_LOW_WAIT:
                begin
                    release_next = 1'b1;
                    state_next   = bhmc_pkg::ST_T1_BEGIN;
                end
                bhmc_pkg::ST_T1_BEGIN, bhmc_pkg::ST_T1_WAIT,
                bhmc_pkg::ST_T2_BEGIN, bhmc_pkg::ST_T2_WAIT:
                begin
                    if (at_duty)
                    begin
                        state_next = bhmc_pkg::ST_FULL_BEGIN;
                    end
                end
                bhmc_pkg::ST_T3_BEGIN, bhmc_pkg::ST_T3_WAIT,
                bhmc_pkg::ST_T4_BEGIN, bhmc_pkg::ST_T4_WAIT:
                begin
                    if (!at_duty)
                    begin
                        state_next = bhmc_pkg::ST_LOW_BEGIN;
                    end
                end
                bhmc_pkg::ST_FULL_BEGIN:
                begin
                    release_next = 1'b0;
                    state_next   = bhmc_pkg::ST_FULL_WAIT;
                end
                bhmc_pkg::ST_FULL_WAIT:
                begin
                    apply_next = 1'b1;
                    state_next = bhmc_pkg::ST_T3_BEGIN;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        else
        begin
            if (state_reg <= bhmc_pkg::ST_LOW_WAIT)
            begin
                release_next = 1'b1;
                if (!below)
                begin
                    state_next = bhmc_pkg::ST_T1_BEGIN;
                end
            end
            else if (state_reg <= bhmc_pkg::ST_T4_WAIT)
            begin
                apply_next   = 1'b0;
                release_next = 1'b0;
                if (below)
                begin
                    state_next = bhmc_pkg::ST_LOW_BEGIN;
                end
                else if (pos >= cfg.on_thr)
                begin
                    state_next = bhmc_pkg::ST_FULL_BEGIN;
                end
            end
            else if (state_reg <= bhmc_pkg::ST_FULL_WAIT)
            begin
                apply_next = 1'b1;
                if (pos < lim)
                begin
                    state_next = bhmc_pkg::ST_T1_BEGIN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bhmc_pkg::ST_LOW_BEGIN;
            apply_reg   <= 1'b0;
            release_reg <= 1'b0;
            estop_reg   <= 1'b0;
        end
        else if (commit)
        begin
            state_reg   <= state_next;
            apply_reg   <= apply_next;
            release_reg <= release_next;
            estop_reg   <= estop_next;
        end
    end

    assign status.brake_on  = apply_reg;
    assign status.brake_off = release_reg;
    assign status.emergency = estop_reg;
    assign status.state     = state_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/brake_handle_mode_controller.sv
`default_nettype none

// Brake handle mode controller. Each input word carries one handle sample and
// the current value of the external pulse counter; each produces exactly one
// output word with the brake apply, release and emergency flags, the handle
// percentage of the low-to-high threshold span (saturated at 255) and the mode
// state after the step. A new word is accepted only once the last one has been
// committed: a single shared restoring divider runs two passes per word
// (percentage, then counter over pulse width), each shifting out every quotient
// bit and then picking up the quotient (the first pickup also reloads the
// divider); then the mode update is committed and the sequencer returns to idle,
// where the next word is accepted. in_stall stays high while a word is
// in work. The finished word sits in the output register, so the next word is
// accepted and divided while it waits; only the commit waits for the output to
// drain. Configuration writes take effect at once and belong to idle periods;
// indexes past the last register are ignored.
module brake_handle_mode_controller (
    input  wire                                clk,
    input  wire                                rst_n,
    // configuration
    input  wire                                cfg_write,
    input  wire  [bhmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [bhmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input words
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [bhmc_pkg::POS_W-1:0]         handle_position,
    input  wire  [7:0]                         pulse_count,
    // output words
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic                               brake_on,
    output logic                               brake_off,
    output logic                               emergency,
    output logic [bhmc_pkg::PCT_W-1:0]         percent,
    output logic [bhmc_pkg::STATE_W-1:0]       mode_state
);

    localparam int DW = bhmc_pkg::DIV_DVD_W;

    bhmc_pkg::bhmc_cfg_t    cfg_reg;
    bhmc_pkg::seq_state_t   seq_reg, seq_next;
    bhmc_pkg::mode_status_t status;

    logic [bhmc_pkg::POS_W-1:0] pos_reg;
    logic [7:0]                 count_reg;
    logic [bhmc_pkg::PCT_W-1:0] pct_reg, pct_next;
    logic [7:0]                 duty_q_reg;
    logic [bhmc_pkg::PCT_W-1:0] pct_out_reg;
    logic                       out_valid_reg;

    logic        in_accept;
    logic        out_free;
    logic        div_start;
    logic        div_sel_duty;
    logic        cap_pct;
    logic        cap_duty;
    logic        commit;
    logic [DW-1:0] div_dividend;
    logic [7:0]  div_divisor;
    logic        div_busy;
    logic        div_done;
    logic [DW-1:0] div_quot;
    logic [7:0]  span_diff;
    logic [7:0]  pw_eff;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_thr      <= bhmc_pkg::ON_THR_RST;
            cfg_reg.low_thr     <= bhmc_pkg::LOW_THR_RST;
            cfg_reg.high_thr    <= bhmc_pkg::HIGH_THR_RST;
            cfg_reg.options     <= bhmc_pkg::OPT_RST;
            cfg_reg.pulse_width <= bhmc_pkg::PW_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bhmc_pkg::CFG_ON_THR:   cfg_reg.on_thr      <= cfg_data;
                bhmc_pkg::CFG_LOW_THR:  cfg_reg.low_thr     <= cfg_data;
                bhmc_pkg::CFG_HIGH_THR: cfg_reg.high_thr    <= cfg_data;
                bhmc_pkg::CFG_OPTIONS:  cfg_reg.options     <= cfg_data[bhmc_pkg::OPT_W-1:0];
                bhmc_pkg::CFG_PULSE_W:  cfg_reg.pulse_width <= cfg_data;
                default:                cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Divider operands: percent pass takes the fresh sample off the port
    always_comb
    begin
        span_diff = handle_position - cfg_reg.low_thr;
        pw_eff    = (cfg_reg.pulse_width == 8'd0) ? 8'd1 : cfg_reg.pulse_width;
        if (div_sel_duty)
        begin
            div_dividend = DW'(count_reg);
            div_divisor  = pw_eff;
        end
        else
        begin
            div_dividend = DW'(span_diff) * DW'(bhmc_pkg::PCT_SCALE);
            div_divisor  = cfg_reg.high_thr - cfg_reg.low_thr;
        end
    end

    // Percent special cases: below low is zero, empty or inverted span or a quotient above 255 saturates
    always_comb
    begin
        if (pos_reg < cfg_reg.low_thr)
        begin
            pct_next = '0;
        end
        else if (cfg_reg.high_thr <= cfg_reg.low_thr)
        begin
            pct_next = bhmc_pkg::PCT_W'(bhmc_pkg::PCT_SAT);
        end
        else if (div_quot > DW'(bhmc_pkg::PCT_SAT))
        begin
            pct_next = bhmc_pkg::PCT_W'(bhmc_pkg::PCT_SAT);
        end
        else
        begin
            pct_next = div_quot[bhmc_pkg::PCT_W-1:0];
        end
    end

    // Sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            bhmc_pkg::SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    seq_next = bhmc_pkg::SEQ_PCT;
                end
            end
            bhmc_pkg::SEQ_PCT:
            begin
                if (div_done)
                begin
                    seq_next = bhmc_pkg::SEQ_DUTY;
                end
            end
            bhmc_pkg::SEQ_DUTY:
            begin
                if (div_done)
                begin
                    seq_next = bhmc_pkg::SEQ_COMMIT;
                end
            end
            bhmc_pkg::SEQ_COMMIT:
            begin
                if (out_free)
                begin
                    seq_next = bhmc_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = bhmc_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall     = 1'b1;
        div_start    = 1'b0;
        div_sel_duty = 1'b0;
        cap_pct      = 1'b0;
        cap_duty     = 1'b0;
        commit       = 1'b0;
        case (seq_reg)
            bhmc_pkg::SEQ_IDLE:
            begin
                in_stall  = 1'b0;
                div_start = in_valid;
            end
            bhmc_pkg::SEQ_PCT:
            begin
                cap_pct      = div_done;
                div_start    = div_done;
                div_sel_duty = 1'b1;
            end
            bhmc_pkg::SEQ_DUTY:
            begin
                cap_duty = div_done;
            end
            bhmc_pkg::SEQ_COMMIT:
            begin
                commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= bhmc_pkg::SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the word under work and the intermediate results
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pos_reg   <= handle_position;
            count_reg <= pulse_count;
        end
        if (cap_pct)
        begin
            pct_reg <= pct_next;
        end
        if (cap_duty)
        begin
            duty_q_reg <= div_quot[7:0];
        end
        if (commit)
        begin
            pct_out_reg <= pct_reg;
        end
    end

    bhmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    bhmc_mode u_mode (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .pos    (pos_reg),
        .pct    (pct_reg),
        .duty_q (duty_q_reg),
        .cfg    (cfg_reg),
        .status (status)
    );

    assign out_valid  = out_valid_reg;
    assign brake_on   = status.brake_on;
    assign brake_off  = status.brake_off;
    assign emergency  = status.emergency;
    assign percent    = pct_out_reg;
    assign mode_state = status.state;

`ifndef SYNTHESIS
    // The mode state never leaves the defined codes
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_state <= 4'd11)
        else $error("mode state outside defined codes");

    // Never restart the divider mid-pass
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // Divider completions only while the sequencer waits on one
    a_div_done_seq: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (seq_reg == bhmc_pkg::SEQ_PCT || seq_reg == bhmc_pkg::SEQ_DUTY))
        else $error("divider done outside a division step");

    // An accepted word starts the percent pass in the next cycle
    a_accept_to_pct: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (seq_reg == bhmc_pkg::SEQ_PCT && div_busy))
        else $error("accepted word did not start division");

    // A commit always presents an output word
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("commit without output word");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/brake_handle_mode_controller_tb.sv
`timescale 1ns / 1ps

module brake_handle_mode_controller_tb;
    import bhmc_pkg::*;

    // Run shape. IDLE_LIMIT covers the long output hold plus one full word
    // plus config writes, several times over.
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_COUNT  = 16;
    localparam int PHASE_WORDS  = 75;
    localparam int QUIET_PHASES = 2;
    localparam int HOLD_WORDS   = 10;

    // Brake arithmetic, kept local so the arithmetic of the prediction does not lean on the package.
    localparam int unsigned PERCENT_SPAN = 100;
    localparam int unsigned PERCENT_SAT  = 255;
    localparam int unsigned STEP_PCT_1   = 20;
    localparam int unsigned STEP_PCT_2   = 40;
    localparam int unsigned STEP_PCT_3   = 60;
    localparam int unsigned STEP_PCT_4   = 80;
    localparam int unsigned DUTY_INC     = 20;
    localparam int unsigned HYST_BAND    = 5;

    // Index past the last register; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic [CFG_DATA_W-1:0] OPTS_PLAIN   = '0;
    localparam logic [CFG_DATA_W-1:0] OPTS_ESTOP   = CFG_DATA_W'(1 << OPT_ESTOP);
    localparam logic [CFG_DATA_W-1:0] OPTS_PULSE   = CFG_DATA_W'(1 << OPT_VAR);
    localparam logic [CFG_DATA_W-1:0] OPTS_STEPPED =
        CFG_DATA_W'((1 << OPT_VAR) | (1 << OPT_STEP));

    typedef struct packed {
        mode_status_t     status;
        logic [PCT_W-1:0] percent;
    } brake_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [POS_W-1:0]      handle_position;
    logic [7:0]            pulse_count;
    logic                  out_valid;
    logic                  out_stall;
    logic                  brake_on;
    logic                  brake_off;
    logic                  emergency;
    logic [PCT_W-1:0]      percent;
    logic [STATE_W-1:0]    mode_state;

    // Shadow of the block: registers, mode state and the three flags.
    bhmc_cfg_t    shadow_cfg;
    brake_state_t handle_state;
    logic         apply_q;
    logic         release_q;
    logic         estop_q;

    // Outstanding result words, oldest first.
    brake_word_t  brake_words_due[$];

    int unsigned  bad_word_count;
    int unsigned  words_seen;
    bit           in_idle_on;
    bit           out_idle_on;
    bit           hold_output;
    int           handle_walk;
    int           count_walk;

    brake_handle_mode_controller dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .handle_position (handle_position),
        .pulse_count     (pulse_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .brake_on        (brake_on),
        .brake_off       (brake_off),
        .emergency       (emergency),
        .percent         (percent),
        .mode_state      (mode_state)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Brake logic prediction
    // ------------------------------------------------------------------

    // Handle position as a percentage of the low..high span. Below the low
    // threshold it is zero; an empty or inverted span pins it at saturation.
    function automatic int unsigned span_percent(logic [POS_W-1:0] pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned q;
        lo = 32'(shadow_cfg.low_thr);
        hi = 32'(shadow_cfg.high_thr);
        if (pos < lo)
            return 0;
        if (hi <= lo)
            return PERCENT_SAT;
        q = (PERCENT_SPAN * (pos - lo)) / (hi - lo);
        return (q > PERCENT_SAT) ? PERCENT_SAT : q;
    endfunction

    // Stepped mode: pulse apply at each 20% step, release when dropping low.
    function automatic void advance_stepped(logic [POS_W-1:0] pos, int unsigned pc);
        logic        below;
        int unsigned gate;
        below = pos < shadow_cfg.low_thr;
        case (handle_state)
            ST_LOW_BEGIN:
            begin
                release_q    = 1'b1;
                handle_state = ST_LOW_WAIT;
            end
            ST_LOW_WAIT:
            begin
                release_q = 1'b0;
                if (pc >= STEP_PCT_1)
                    handle_state = ST_T1_BEGIN;
            end
            ST_T1_BEGIN, ST_T2_BEGIN, ST_T3_BEGIN, ST_T4_BEGIN, ST_FULL_BEGIN:
            begin
                apply_q      = 1'b1;
                handle_state = brake_state_t'(handle_state + 1);
            end
            ST_T1_WAIT, ST_T2_WAIT, ST_T3_WAIT:
            begin
                apply_q = 1'b0;
                gate = (handle_state == ST_T1_WAIT) ? STEP_PCT_2 :
                       (handle_state == ST_T2_WAIT) ? STEP_PCT_3 : STEP_PCT_4;
                if (below)
                    handle_state = ST_LOW_BEGIN;
                else if (pc >= gate)
                    handle_state = brake_state_t'(handle_state + 1);
            end
            ST_T4_WAIT:
            begin
                apply_q = 1'b0;
                if (below)
                    handle_state = ST_LOW_BEGIN;
                else if (pos > shadow_cfg.high_thr)
                    handle_state = ST_FULL_BEGIN;
            end
            ST_FULL_WAIT:
            begin
                apply_q = 1'b0;
                if (below)
                    handle_state = ST_LOW_BEGIN;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Pulse mode: compare the percentage with a duty level from the counter.
    function automatic void advance_pulse(int unsigned pc, logic [7:0] cnt);
        int unsigned w;
        int unsigned duty;
        w    = (shadow_cfg.pulse_width == 0) ? 1 : 32'(shadow_cfg.pulse_width);
        duty = (cnt / w + 1) * DUTY_INC;
        case (handle_state)
            ST_LOW_BEGIN:
            begin
                apply_q      = 1'b0;
                handle_state = ST_LOW_WAIT;
            end
            ST_LOW_WAIT:
            begin
                release_q    = 1'b1;
                handle_state = ST_T1_BEGIN;
            end
            ST_T1_BEGIN, ST_T1_WAIT, ST_T2_BEGIN, ST_T2_WAIT:
            begin
                if (pc >= duty)
                    handle_state = ST_FULL_BEGIN;
            end
            ST_T3_BEGIN, ST_T3_WAIT, ST_T4_BEGIN, ST_T4_WAIT:
            begin
                if (pc < duty)
                    handle_state = ST_LOW_BEGIN;
            end
            ST_FULL_BEGIN:
            begin
                release_q    = 1'b0;
                handle_state = ST_FULL_WAIT;
            end
            ST_FULL_WAIT:
            begin
                apply_q      = 1'b1;
                handle_state = ST_T3_BEGIN;
            end
            default:
            begin
            end
        endcase
    endfunction

    // On/off mode with a hysteresis band below the on threshold.
    function automatic void advance_onoff(logic [POS_W-1:0] pos);
        int unsigned lim;
        if (handle_state <= ST_LOW_WAIT)
        begin
            release_q = 1'b1;
            if (pos >= shadow_cfg.low_thr)
                handle_state = ST_T1_BEGIN;
        end
        else if (handle_state <= ST_T4_WAIT)
        begin
            apply_q   = 1'b0;
            release_q = 1'b0;
            if (pos < shadow_cfg.low_thr)
                handle_state = ST_LOW_BEGIN;
            else if (pos >= shadow_cfg.on_thr)
                handle_state = ST_FULL_BEGIN;
        end
        else if (handle_state <= ST_FULL_WAIT)
        begin
            apply_q = 1'b1;
            lim = (shadow_cfg.on_thr > HYST_BAND) ? shadow_cfg.on_thr - HYST_BAND : 0;
            if (shadow_cfg.low_thr > lim)
                lim = 32'(shadow_cfg.low_thr);
            if (pos < lim)
                handle_state = ST_T1_BEGIN;
        end
    endfunction

    // Advance the shadow by one handle sample and return the word it yields.
    function automatic brake_word_t advance_brake_logic(logic [POS_W-1:0] pos,
                                                         logic [7:0] cnt);
        int unsigned pc;
        brake_word_t word;
        pc = span_percent(pos);
        // Emergency latches above high, clears below low, holds in between.
        if (shadow_cfg.options[OPT_ESTOP])
        begin
            if (pos < shadow_cfg.low_thr)
                estop_q = 1'b0;
            if (pos > shadow_cfg.high_thr)
                estop_q = 1'b1;
        end
        else
            estop_q = 1'b0;
        if (shadow_cfg.options[OPT_VAR] && shadow_cfg.options[OPT_STEP])
            advance_stepped(pos, pc);
        else if (shadow_cfg.options[OPT_VAR])
            advance_pulse(pc, cnt);
        else
            advance_onoff(pos);
        word.status.brake_on  = apply_q;
        word.status.brake_off = release_q;
        word.status.emergency = estop_q;
        word.status.state     = handle_state;
        word.percent          = pc[PCT_W-1:0];
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_failure(string what);
        bad_word_count++;
        if (bad_word_count <= REPORT_LIMIT)
            $display("mismatch at %0t, output word %0d: %s", $time, words_seen, what);
    endtask

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    // Sample both handshakes at the rising edge. Retire the output word first:
    // it always belongs to an earlier input word than one accepted this edge.
    always @(posedge clk)
    begin : word_checker
        brake_word_t due;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (brake_words_due.size() == 0)
                    note_failure("output word with nothing outstanding");
                else
                begin
                    due = brake_words_due.pop_front();
                    check_field("brake_on", 8'(due.status.brake_on), 8'(brake_on));
                    check_field("brake_off", 8'(due.status.brake_off), 8'(brake_off));
                    check_field("emergency", 8'(due.status.emergency), 8'(emergency));
                    check_field("percent", due.percent, percent);
                    check_field("mode_state", 8'(due.status.state), 8'(mode_state));
                end
            end
            if (in_valid && !in_stall)
                brake_words_due.push_back(advance_brake_logic(handle_position, pulse_count));
        end
    end

    // Watchdog: give up once nothing has moved on either side for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("brake_handle_mode_controller_tb: FAIL");
        $finish;
    end

    // Receiver: random stall bursts, or one long hold when asked for.
    initial
    begin : receiver
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (out_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one word and return at the edge that accepts it. Valid stays high
    // afterwards so the next call can follow back to back.
    task automatic send_word(logic [POS_W-1:0] pos, logic [7:0] cnt);
        @(negedge clk);
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid        <= 1'b1;
        handle_position <= pos;
        pulse_count     <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding word has come back.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (brake_words_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; the shadow follows the same masking as the block.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_ON_THR:   shadow_cfg.on_thr      = data;
            CFG_LOW_THR:  shadow_cfg.low_thr     = data;
            CFG_HIGH_THR: shadow_cfg.high_thr    = data;
            CFG_OPTIONS:  shadow_cfg.options     = data[OPT_W-1:0];
            CFG_PULSE_W:  shadow_cfg.pulse_width = data;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] on_v, logic [7:0] lo, logic [7:0] hi,
                              logic [CFG_DATA_W-1:0] opts, logic [7:0] pw);
        wait_idle();
        write_reg(CFG_ON_THR, on_v);
        write_reg(CFG_LOW_THR, lo);
        write_reg(CFG_HIGH_THR, hi);
        write_reg(CFG_OPTIONS, opts);
        write_reg(CFG_PULSE_W, pw);
    endtask

    // Handle moves like a lever: mostly small drifts, now and then a jump.
    function automatic logic [POS_W-1:0] next_handle();
        if ($urandom_range(0, 4) == 0)
            handle_walk = int'($urandom_range(0, 255));
        else
        begin
            handle_walk += int'($urandom_range(0, 40)) - 20;
            if (handle_walk < 0)
                handle_walk = 0;
            if (handle_walk > 255)
                handle_walk = 255;
        end
        return handle_walk[POS_W-1:0];
    endfunction

    // Pulse counter runs forward; occasionally sample it at a random point.
    function automatic logic [7:0] next_count();
        if ($urandom_range(0, 4) == 0)
            count_walk = int'($urandom_range(0, 255));
        else
            count_walk = (count_walk + int'($urandom_range(0, 16))) % 256;
        return count_walk[7:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // On/off mode at the reset register values: low edge at 20, on at 128,
    // release of the full state just under the hysteresis band (123).
    task automatic test_onoff_reset_values();
        send_word(8'd0, 8'd0);
        send_word(8'd20, 8'hFF);
        send_word(8'd255, 8'd0);
        send_word(8'd123, 8'hAA);
        send_word(8'd122, 8'h55);
        send_word(8'd19, 8'hFF);
        send_word(8'd19, 8'd0);
    endtask

    // Percentage corners: empty span, inverted span, a quotient that would
    // wrap without saturation, and the full 0..255 span.
    task automatic test_percent_corners();
        set_config(8'd128, 8'd100, 8'd100, OPTS_PLAIN, 8'd1);
        send_word(8'd99, 8'd0);
        send_word(8'd100, 8'd0);
        set_config(8'd128, 8'd100, 8'd50, OPTS_PLAIN, 8'd1);
        send_word(8'd255, 8'd0);
        set_config(8'd128, 8'd0, 8'd1, OPTS_PLAIN, 8'd1);
        send_word(8'd255, 8'd0);
        wait_idle();
        // A write past the last register must leave everything alone.
        write_reg(CFG_UNUSED, 8'hFF);
        write_reg(CFG_HIGH_THR, 8'd255);
        send_word(8'd255, 8'd0);
    endtask

    // Emergency latch: set above high, hold between, clear below low; with
    // the option off it clears on every sample.
    task automatic test_emergency_latch();
        set_config(8'd128, 8'd20, 8'd235, OPTS_ESTOP, 8'd1);
        send_word(8'd236, 8'd0);
        send_word(8'd235, 8'd0);
        send_word(8'd20, 8'd0);
        send_word(8'd19, 8'd0);
        send_word(8'd255, 8'd0);
        set_config(8'd128, 8'd20, 8'd235, OPTS_PLAIN, 8'd1);
        send_word(8'd255, 8'd0);
    endtask

    // Pulse mode with a zero width (must act as one), then the widest width.
    task automatic test_pulse_duty();
        set_config(8'd128, 8'd20, 8'd235, OPTS_PULSE, 8'd0);
        send_word(8'd235, 8'd0);
        send_word(8'd235, 8'd0);
        send_word(8'd235, 8'd255);
        set_config(8'd128, 8'd20, 8'd235, OPTS_PULSE, 8'd255);
        send_word(8'd235, 8'd255);
        send_word(8'd10, 8'd3);
    endtask

    // Stepped mode with emergency on: climb the steps, then drop to release.
    task automatic test_stepped_ramp();
        set_config(8'd128, 8'd20, 8'd235, OPTS_STEPPED | OPTS_ESTOP, 8'd255);
        repeat (6) send_word(8'd255, 8'd0);
        repeat (2) send_word(8'd0, 8'd0);
    endtask

    // Hold the output for a long stretch while words keep coming back to back,
    // so the output register fills and the block stalls its input.
    task automatic test_output_hold();
        in_idle_on  = 1'b0;
        hold_output = 1'b1;
        repeat (HOLD_WORDS) send_word(next_handle(), next_count());
        in_idle_on = 1'b1;
    endtask

    // Random phases: sweep all option settings twice, with thresholds and
    // pulse width often at their extremes. The last phases run without gaps.
    task automatic test_random_phases();
        logic [7:0]            lo;
        logic [7:0]            hi;
        logic [7:0]            on_v;
        logic [7:0]            pw;
        logic [CFG_DATA_W-1:0] opts;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase >= PHASE_COUNT - QUIET_PHASES)
            begin
                in_idle_on  = 1'b0;
                out_idle_on = 1'b0;
            end
            else
            begin
                in_idle_on  = ($urandom_range(0, 5) != 0);
                out_idle_on = ($urandom_range(0, 5) != 0);
            end
            case ($urandom_range(0, 5))
                0:       lo = 8'd0;
                1:       lo = 8'd255;
                default: lo = 8'($urandom_range(0, 120));
            endcase
            case ($urandom_range(0, 5))
                0:       hi = 8'd255;
                1:       hi = lo;
                2:       hi = 8'($urandom_range(0, lo));
                default: hi = (lo == 8'd255) ? lo : 8'(lo + $urandom_range(1, 255 - lo));
            endcase
            case ($urandom_range(0, 4))
                0:       on_v = 8'd0;
                1:       on_v = 8'd255;
                default: on_v = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       pw = 8'd0;
                1:       pw = 8'd255;
                2:       pw = 8'd1;
                default: pw = 8'($urandom_range(1, 20));
            endcase
            // Junk in the upper data bits must be dropped by the options register.
            opts = CFG_DATA_W'(($urandom_range(0, 31) << OPT_W) | (phase % 8));
            set_config(on_v, lo, hi, opts, pw);
            repeat (PHASE_WORDS) send_word(next_handle(), next_count());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        handle_position = '0;
        pulse_count     = '0;
        in_idle_on      = 1'b1;
        out_idle_on     = 1'b1;
        hold_output     = 1'b0;
        bad_word_count  = 0;
        words_seen      = 0;
        handle_walk     = 0;
        count_walk      = 0;

        shadow_cfg.on_thr      = ON_THR_RST;
        shadow_cfg.low_thr     = LOW_THR_RST;
        shadow_cfg.high_thr    = HIGH_THR_RST;
        shadow_cfg.options     = OPT_RST;
        shadow_cfg.pulse_width = PW_RST;
        handle_state = ST_LOW_BEGIN;
        apply_q      = 1'b0;
        release_q    = 1'b0;
        estop_q      = 1'b0;

        // Hold reset, then release it away from the sampling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_onoff_reset_values();
        test_percent_corners();
        test_emergency_latch();
        test_pulse_duty();
        test_stepped_ramp();
        test_output_hold();
        test_random_phases();

        // Drain, then give a stray extra word time to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (brake_words_due.size() != 0)
            note_failure($sformatf("%0d words never came back", brake_words_due.size()));

        if (bad_word_count == 0)
            $display("brake_handle_mode_controller_tb: PASS");
        else
            $display("brake_handle_mode_controller_tb: FAIL");
        $finish;
    end

endmodule
